// ===== rtl/rspe_pkg.sv =====
// Shared types, constants and GF(256) arithmetic for the Reed-Solomon parity encoder.
`timescale 1ns / 1ps

package rspe_pkg;

  localparam int MAX_ECC_DEFAULT = 32;
  localparam int ECC_RESET = 10;
  localparam logic [7:0] GF_POLY_LOW = 8'h1D;

  typedef struct packed {
    logic       init;
    logic       build;
    logic       absorb;
    logic       last;
    logic       capture;
    logic       drain;
    logic [7:0] mul_op;
  } rspe_ctl_t;

  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ x;
      end
      x = gf_xtime(x);
    end
    return p;
  endfunction

endpackage

// ===== rtl/reed_solomon_parity_encoder.sv =====
// Top level of the Reed-Solomon parity encoder: control, generator build and output drain.
//
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last_byte
// m_axis    out  m_tvalid/m_tready  m_tdata = parity_byte, m_tlast = last_parity
// config    in   ecc_count_we       ecc_count
//
// One message byte is absorbed per cycle while s_tready is high; every cell updates in the
// same cycle. A final byte loads the parity bytes into the output shift chain, which drains
// one per cycle while m_tready is high, as the next block already streams in; a final byte
// also waits while parity is pending. After reset or an ecc_count write, the generator is built
// one root per cycle, with s_tready low; reset is synchronous and acts as a write of ten.
`timescale 1ns / 1ps

module reed_solomon_parity_encoder
  import rspe_pkg::*;
#(
  parameter int MAX_ECC = MAX_ECC_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       ecc_count_we,
  input  logic [5:0] ecc_count,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] parity_byte
  output logic       m_tlast
);

  localparam int CW = $clog2(MAX_ECC + 1);
  localparam int IW = (MAX_ECC > 1) ? $clog2(MAX_ECC) : 1;

  logic [IW-1:0] n_m1;
  logic [CW-1:0] bcnt;
  logic [CW-1:0] cnt;
  logic [7:0]    root;
  logic [6:0]    cfg_raw;
  logic [6:0]    cfg_n;
  logic          building;
  logic          in_xfer;
  logic          capture;
  logic          drain;
  logic [7:0]    fb;
  rspe_ctl_t     ctl;

  logic [7:0] coef [MAX_ECC];
  logic [7:0] rem  [MAX_ECC];
  logic [7:0] par  [MAX_ECC];

  always_comb begin
    cfg_raw = rst ? 7'(ECC_RESET) : {1'b0, ecc_count};
    if (cfg_raw == 7'd0) begin
      cfg_n = 7'd1;
    end else if (cfg_raw > 7'(MAX_ECC)) begin
      cfg_n = 7'(MAX_ECC);
    end else begin
      cfg_n = cfg_raw;
    end
  end

  assign building = (bcnt != '0);
  assign m_tvalid = (cnt != '0);
  assign m_tlast  = (cnt == CW'(1));
  assign m_tdata  = par[n_m1];
  assign drain    = m_tvalid && m_tready;
  assign s_tready = !building && !ecc_count_we &&
                    (!s_tlast || !m_tvalid || (m_tlast && m_tready));
  assign in_xfer  = s_tvalid && s_tready;
  assign capture  = in_xfer && s_tlast;
  assign fb       = s_tdata ^ rem[n_m1];

  always_comb begin
    ctl.init    = rst || ecc_count_we;
    ctl.build   = building;
    ctl.absorb  = in_xfer;
    ctl.last    = s_tlast;
    ctl.capture = capture;
    ctl.drain   = drain;
    ctl.mul_op  = building ? root : fb;
  end

  always_ff @(posedge clk) begin
    if (rst || ecc_count_we) begin
      n_m1 <= IW'(cfg_n - 7'd1);
      bcnt <= CW'(cfg_n);
      root <= 8'h01;
      cnt  <= '0;
    end else begin
      if (building) begin
        bcnt <= bcnt - CW'(1);
        root <= gf_xtime(root);
      end
      if (capture) begin
        cnt <= CW'(n_m1) + CW'(1);
      end else if (drain) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  for (genvar d = 0; d < MAX_ECC; d++) begin : g_cell
    if (d == 0) begin : g_head
      rspe_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .seed      (8'h01),
        .prev_coef (8'h00),
        .prev_rem  (8'h00),
        .prev_par  (8'h00),
        .coef      (coef[d]),
        .rem       (rem[d]),
        .par       (par[d])
      );
    end else begin : g_body
      rspe_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .seed      (8'h00),
        .prev_coef (coef[d-1]),
        .prev_rem  (rem[d-1]),
        .prev_par  (par[d-1]),
        .coef      (coef[d]),
        .rem       (rem[d]),
        .par       (par[d])
      );
    end
  end

  a_no_input_while_building: assert property (@(posedge clk) disable iff (rst)
    building |-> !in_xfer)
    else $error("Input transfer accepted while the generator is being built.");

  a_capture_fills_output: assert property (@(posedge clk) disable iff (rst)
    capture |=> (m_tvalid && (cnt == CW'(n_m1) + CW'(1))))
    else $error("Final byte did not load a full parity block.");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(n_m1) + CW'(1))
    else $error("Parity count exceeds the configured length.");

  a_write_clears: assert property (@(posedge clk) disable iff (rst)
    ecc_count_we |=> (rem[0] == 8'h00 && !m_tvalid))
    else $error("Configuration write did not clear the remainder and output.");

endmodule

// ===== rtl/rspe_cell.sv =====
// One cell of the encoder chain: a generator coefficient, a remainder byte and a parity byte.
`timescale 1ns / 1ps

module rspe_cell
  import rspe_pkg::*;
(
  input  logic       clk,
  input  rspe_ctl_t  ctl,
  input  logic [7:0] seed,
  input  logic [7:0] prev_coef,
  input  logic [7:0] prev_rem,
  input  logic [7:0] prev_par,
  output logic [7:0] coef,
  output logic [7:0] rem,
  output logic [7:0] par
);

  logic [7:0] product;
  logic [7:0] coef_next;
  logic [7:0] rem_next;

  always_comb begin
    product   = gf_mul(ctl.mul_op, coef);
    coef_next = prev_coef ^ product;
    rem_next  = prev_rem ^ product;
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      coef <= seed;
    end else if (ctl.build) begin
      coef <= coef_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      rem <= 8'h00;
    end else if (ctl.absorb) begin
      rem <= ctl.last ? 8'h00 : rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      par <= rem_next;
    end else if (ctl.drain) begin
      par <= prev_par;
    end
  end

endmodule
